>>> hw/rtl/fsf_pkg.sv
// Package with shared types and constants of the footprint span finder.
package fsf_pkg;
    localparam int COORD_BITS = 32;
    localparam int STN_BITS   = COORD_BITS - 1;
    localparam int TBITS      = 16;
    // Doubled coordinates and their differences need three extra bits.
    localparam int WIDE_BITS  = COORD_BITS + 3;
    // Clip ratios: sign plus magnitude up to 2.0.
    localparam int T_BITS     = TBITS + 3;
    localparam logic signed [T_BITS-1:0] T_ONE = T_BITS'(1) <<< TBITS;
    localparam logic signed [T_BITS-1:0] T_TWO = T_BITS'(2) <<< TBITS;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_X   = 2'd2;
    localparam logic [1:0] REG_SIZE_Y   = 2'd3;

    typedef struct packed {
        logic                  start;
        logic [WIDE_BITS-1:0]  num_mag;
        logic [WIDE_BITS-1:0]  den_mag;
        logic                  neg;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [T_BITS-1:0] ratio;
    } div_rsp_t;
endpackage

>>> hw/rtl/fsf_divider.sv
// Restoring divider giving a saturated signed clip ratio, one quotient bit per cycle.
module fsf_divider import fsf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [WIDE_BITS:0]   rem_reg, rem_next;
    logic [WIDE_BITS-1:0] den_reg, den_next;
    logic [TBITS-1:0]     frac_reg, frac_next;
    logic                 ip_reg, ip_next;
    logic                 neg_reg, neg_next;
    logic                 sat_reg, sat_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WIDE_BITS:0]   shifted;
    logic [TBITS+1:0]     mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        frac_reg <= frac_next;
        ip_reg   <= ip_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
    end

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        frac_next = frac_reg;
        ip_next   = ip_reg;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[WIDE_BITS-1:0], 1'b0};
        if (req.start)
        begin
            den_next  = req.den_mag;
            neg_next  = req.neg;
            sat_next  = {1'b0, req.num_mag} >= {req.den_mag, 1'b0};
            ip_next   = req.num_mag >= req.den_mag;
            rem_next  = {1'b0, req.num_mag >= req.den_mag ?
                         req.num_mag - req.den_mag : req.num_mag};
            frac_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next  = shifted - {1'b0, den_reg};
                frac_next = {frac_reg[TBITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                frac_next = {frac_reg[TBITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(TBITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        mag = sat_reg ? (TBITS+2)'(T_TWO) : {1'b0, ip_reg, frac_reg};
        if (neg_reg)
        begin
            if (mag > (TBITS+2)'(T_ONE))
                mag = (TBITS+2)'(T_ONE);
            rsp.ratio = -$signed({1'b0, mag});
        end
        else
            rsp.ratio = $signed({1'b0, mag});
        rsp.done = done_reg;
    end
endmodule

>>> hw/rtl/footprint_span_finder.sv
// Top level of the footprint span finder: sequencer, clip state and span tracking.
// Each accepted request is a trajectory sample; the segment from the previous
// sample is clipped against the configured rectangle (Liang-Barsky, doubled
// coordinates) using one shared restoring divider for up to four ratios, then
// two stations are interpolated on one shared 31x17 multiplier, the t0
// station in ST_MUL0 and the t1 station in ST_MUL1.
// in_ready is low while a sample is being processed and while results wait.
// Up to two results come out per sample, a closed span first and then the
// final result when last_sample is set. Configuration writes are taken at any
// time but are meant to happen only while idle.
module footprint_span_finder import fsf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [COORD_BITS-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic [STN_BITS-1:0]         station,
    input  logic                        first_sample,
    input  logic                        last_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [STN_BITS-1:0]         entry_station,
    output logic [STN_BITS-1:0]         exit_station,
    output logic                        span_present,
    output logic                        final_result
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_AXIS  = 8'b00000010,
        ST_DIV   = 8'b00000100,
        ST_MUL0  = 8'b00001000,
        ST_MUL1  = 8'b00010000,
        ST_SPAN  = 8'b00100000,
        ST_OUT1  = 8'b01000000,
        ST_OUT2  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [STN_BITS-1:0]          sx_reg, sy_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic [STN_BITS-1:0]          prev_s_reg, cur_s_reg;
    logic                         last_reg;
    logic                         have_prev_reg, span_open_reg;
    logic [STN_BITS-1:0]          open_entry_reg, open_exit_reg;
    logic signed [T_BITS-1:0]     t0_reg, t1_reg, en_reg;
    logic                         axis_reg;   // 0 for x, 1 for y
    logic                         half_reg;   // 0 for low edge ratio, 1 for high
    logic [STN_BITS-1:0]          s0_reg;
    logic                         o1_pend_reg, o2_pend_reg;
    logic [STN_BITS-1:0]          o1_en_reg, o1_ex_reg;
    logic [STN_BITS-1:0]          o2_en_reg, o2_ex_reg;
    logic                         o2_pres_reg;

    div_req_t req;
    div_rsp_t rsp;

    fsf_divider u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // Current axis operands in doubled coordinates.
    logic signed [WIDE_BITS-1:0] a2, lo, hi, d2, num;
    always_comb
    begin
        if (!axis_reg)
        begin
            a2 = WIDE_BITS'(prev_x_reg) <<< 1;
            lo = (WIDE_BITS'(cx_reg) <<< 1) - $signed(WIDE_BITS'(sx_reg));
            hi = (WIDE_BITS'(cx_reg) <<< 1) + $signed(WIDE_BITS'(sx_reg));
            d2 = (WIDE_BITS'(cur_x_reg) - WIDE_BITS'(prev_x_reg)) <<< 1;
        end
        else
        begin
            a2 = WIDE_BITS'(prev_y_reg) <<< 1;
            lo = (WIDE_BITS'(cy_reg) <<< 1) - $signed(WIDE_BITS'(sy_reg));
            hi = (WIDE_BITS'(cy_reg) <<< 1) + $signed(WIDE_BITS'(sy_reg));
            d2 = (WIDE_BITS'(cur_y_reg) - WIDE_BITS'(prev_y_reg)) <<< 1;
        end
        // The low edge ratio starts from ST_AXIS, the high edge ratio is started
        // in ST_DIV as the low one completes.
        num = (state_reg == ST_DIV) ? hi - a2 : lo - a2;
        req.num_mag = num[WIDE_BITS-1] ? WIDE_BITS'(-num) : WIDE_BITS'(num);
        req.den_mag = d2[WIDE_BITS-1] ? WIDE_BITS'(-d2) : WIDE_BITS'(d2);
        req.neg     = num[WIDE_BITS-1] != d2[WIDE_BITS-1] && num != '0;
        req.start   = 1'b0;
        if (state_reg == ST_AXIS && d2 != '0)
            req.start = 1'b1;
        if (state_reg == ST_DIV && rsp.done && !half_reg)
            req.start = 1'b1;
    end

    // Ratios merged into [t0,t1] after both edges of an axis are known.
    logic signed [T_BITS-1:0] rmin, rmax, nt0, nt1;
    always_comb
    begin
        rmin = (en_reg > rsp.ratio) ? rsp.ratio : en_reg;
        rmax = (en_reg > rsp.ratio) ? en_reg : rsp.ratio;
        nt0  = (rmin > t0_reg) ? rmin : t0_reg;
        nt1  = (rmax < t1_reg) ? rmax : t1_reg;
    end

    // Shared multiplier for the station interpolation.
    logic                     ds_neg;
    logic [STN_BITS-1:0]      ds_mag, lerp_s;
    logic signed [T_BITS-1:0] t_sel;
    logic [TBITS:0]           t_u;
    logic [STN_BITS+TBITS:0]  prod;
    logic [STN_BITS-1:0]      p_part;
    always_comb
    begin
        ds_neg = cur_s_reg < prev_s_reg;
        ds_mag = ds_neg ? prev_s_reg - cur_s_reg : cur_s_reg - prev_s_reg;
        t_sel  = (state_reg == ST_MUL0) ? t0_reg : t1_reg;
        if (t_sel < 0)
            t_u = '0;
        else if (t_sel > T_ONE)
            t_u = (TBITS+1)'(T_ONE);
        else
            t_u = t_sel[TBITS:0];
        prod   = ds_mag * t_u + ((STN_BITS+TBITS+1)'(1) << (TBITS - 1));
        p_part = prod[STN_BITS+TBITS-1:TBITS];
        lerp_s = ds_neg ? prev_s_reg - p_part : prev_s_reg + p_part;
    end

    // Axis with a zero delta: point in range test.
    logic point_in;
    assign point_in = (a2 >= lo) && (a2 <= hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cx_reg        <= '0;
            cy_reg        <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_s_reg    <= '0;
            have_prev_reg <= 1'b0;
            span_open_reg <= 1'b0;
            open_entry_reg <= '0;
            open_exit_reg <= '0;
            o1_pend_reg   <= 1'b0;
            o2_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CENTER_X: cx_reg <= cfg_data;
                    REG_CENTER_Y: cy_reg <= cfg_data;
                    REG_SIZE_X:   sx_reg <= cfg_data[STN_BITS-1:0];
                    REG_SIZE_Y:   sy_reg <= cfg_data[STN_BITS-1:0];
                    default:      ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cur_x_reg <= pos_x;
                        cur_y_reg <= pos_y;
                        cur_s_reg <= station;
                        last_reg  <= last_sample;
                        t0_reg    <= '0;
                        t1_reg    <= T_ONE;
                        axis_reg  <= 1'b0;
                        half_reg  <= 1'b0;
                        o1_pend_reg <= 1'b0;
                        o2_pend_reg <= 1'b0;
                        if (first_sample)
                        begin
                            have_prev_reg <= 1'b0;
                            span_open_reg <= 1'b0;
                        end
                    end
                end
                ST_AXIS:
                begin
                    if (d2 == '0 && point_in)
                        axis_reg <= 1'b1;
                end
                ST_DIV:
                begin
                    if (rsp.done)
                    begin
                        if (!half_reg)
                        begin
                            en_reg   <= rsp.ratio;
                            half_reg <= 1'b1;
                        end
                        else
                        begin
                            half_reg <= 1'b0;
                            t0_reg   <= nt0;
                            t1_reg   <= nt1;
                            if (nt0 <= nt1)
                                axis_reg <= 1'b1;
                        end
                    end
                end
                ST_MUL0:
                    s0_reg <= lerp_s;
                ST_MUL1:
                begin
                    if (lerp_s > s0_reg)
                    begin
                        if (span_open_reg && s0_reg <= open_exit_reg)
                        begin
                            if (lerp_s > open_exit_reg)
                                open_exit_reg <= lerp_s;
                        end
                        else
                        begin
                            if (span_open_reg)
                            begin
                                o1_pend_reg <= 1'b1;
                                o1_en_reg   <= open_entry_reg;
                                o1_ex_reg   <= open_exit_reg;
                            end
                            span_open_reg  <= 1'b1;
                            open_entry_reg <= s0_reg;
                            open_exit_reg  <= lerp_s;
                        end
                    end
                end
                ST_SPAN:
                begin
                    // Commit the sample and, on the last sample, prepare the final result.
                    prev_x_reg    <= cur_x_reg;
                    prev_y_reg    <= cur_y_reg;
                    prev_s_reg    <= cur_s_reg;
                    have_prev_reg <= !last_reg;
                    if (last_reg)
                    begin
                        o2_pend_reg   <= 1'b1;
                        o2_pres_reg   <= span_open_reg;
                        o2_en_reg     <= span_open_reg ? open_entry_reg : '0;
                        o2_ex_reg     <= span_open_reg ? open_exit_reg : '0;
                        span_open_reg <= 1'b0;
                    end
                end
                ST_OUT1:
                    if (out_ready)
                        o1_pend_reg <= 1'b0;
                ST_OUT2:
                    if (out_ready)
                        o2_pend_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (first_sample || !have_prev_reg) ? ST_SPAN : ST_AXIS;
            ST_AXIS:
                if (d2 != '0)
                    state_next = ST_DIV;
                else if (!point_in)
                    state_next = ST_SPAN;
                else if (axis_reg)
                    state_next = ST_MUL0;
            ST_DIV:
                if (rsp.done && half_reg)
                begin
                    if (nt0 > nt1)
                        state_next = ST_SPAN;
                    else if (axis_reg)
                        state_next = (nt1 >= 0 && nt0 <= T_ONE) ? ST_MUL0 : ST_SPAN;
                    else
                        state_next = ST_AXIS;
                end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_SPAN;
            ST_SPAN: state_next = ST_OUT1;
            ST_OUT1:
                if (!o1_pend_reg || out_ready)
                    state_next = ST_OUT2;
            ST_OUT2:
                if (!o2_pend_reg || out_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // A point-in-range y axis after x: reuse ST_AXIS path with its own check.
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        out_valid     = 1'b0;
        entry_station = o1_en_reg;
        exit_station  = o1_ex_reg;
        span_present  = 1'b1;
        final_result  = 1'b0;
        if (state_reg == ST_OUT1)
            out_valid = o1_pend_reg;
        else if (state_reg == ST_OUT2)
        begin
            out_valid     = o2_pend_reg;
            entry_station = o2_en_reg;
            exit_station  = o2_ex_reg;
            span_present  = o2_pres_reg;
            final_result  = 1'b1;
        end
    end
endmodule
